// ===== sv/idms_pkg.sv =====
// ----------------------------------------------------------------------------
// idms_pkg: shared types for the invariant divisor magic search core
// Operation codes of the shared add/subtract step unit.
// ----------------------------------------------------------------------------
package idms_pkg;

    typedef enum logic [1:0] {
        OP_DIV = 2'b01,
        OP_ADD = 2'b10
    } idms_op_t;

endpackage

// ===== sv/invariant_divisor_magic_search_core.sv =====
// Sequence: divide 2^W-1 by the divisor, four setup steps, then per shift
// trial an evaluate step and an advance step, plus a multiply pass when the
// cheap checks pass; all on one adder.
// Throughput: one item at a time; s_ready is high only when idle.
// Reset: aresetn synchronous active low clears the sequencer and m_valid.
// ----------------------------------------------------------------------------
// invariant_divisor_magic_search_core: magic multiplier/shift search
// Finds m and s so that floor(x/p) = hi(m*x) >> s for every W-bit x.
// ----------------------------------------------------------------------------
module invariant_divisor_magic_search_core #(
    parameter int WORD_WIDTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_divisor,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_multiplier,
    output logic [5:0]  m_shift_amount,
    output logic        m_found
);
    import idms_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int CW = $clog2(W);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DIV    = 9'b000000010,
        ST_PREPC2 = 9'b000000100,
        ST_PREPQ2 = 9'b000001000,
        ST_PREPR  = 9'b000010000,
        ST_PREPQ  = 9'b000100000,
        ST_EVAL   = 9'b001000000,
        ST_MUL    = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t       state_reg, state_next;
    logic [W-1:0] p_reg, p_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] q1_reg, q1_next;
    logic [W-1:0] q2_reg, q2_next;
    logic [W-1:0] c2_reg, c2_next;
    logic [W:0]   bq_reg, bq_next;
    logic [W-1:0] m_reg, m_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] mulr_reg, mulr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] s_reg, s_next;
    logic         wrap_reg, wrap_next;
    logic         chk_reg, chk_next;
    logic [W-1:0] rm_reg, rm_next;
    logic [CW-1:0] rs_reg, rs_next;
    logic         rf_reg, rf_next;
    logic         mv_reg, mv_next;
    logic [W-1:0] om_reg, om_next;
    logic [CW-1:0] os_reg, os_next;
    logic         of_reg, of_next;

    idms_op_t     u_op;
    logic [W-1:0] u_a, u_b, u_res;
    logic         u_bit, u_cin, u_flag;
    logic [W:0]   u_sum;

    logic         pass12, pass3;
    logic [CW:0]  s_inc;
    logic         last_trial;

    idms_step_unit #(.W(W)) u_step (
        .op     (u_op),
        .a      (u_a),
        .b      (u_b),
        .bit_in (u_bit),
        .cin    (u_cin),
        .result (u_res),
        .flag   (u_flag),
        .sum_out(u_sum)
    );

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = mv_reg;
    assign m_multiplier   = 64'(om_reg);
    assign m_shift_amount = 6'(os_reg);
    assign m_found        = of_reg;

    assign pass12     = !bq_reg[W] && !(&bq_reg[W-1:0]);
    assign pass3      = ((bq_reg[W-1:0] >> s_reg) == q1_reg);
    assign s_inc      = {1'b0, s_reg} + (CW+1)'(1);
    assign last_trial = (s_reg == CW'(W-1)) || ((p_reg >> s_inc) == '0);

    always_comb begin
        u_op  = OP_ADD;
        u_a   = '0;
        u_b   = '0;
        u_bit = 1'b0;
        u_cin = 1'b0;
        unique case (state_reg)
            ST_DIV: begin
                u_op  = OP_DIV;
                u_a   = rem_reg;
                u_b   = p_reg;
                u_bit = 1'b1;
            end
            ST_PREPC2: begin
                u_a = ~rem_reg;
                u_b = '1;
            end
            ST_PREPQ2: begin
                u_a = q1_reg;
                u_b = '1;
            end
            ST_PREPR: begin
                u_a   = rem_reg;
                u_cin = 1'b1;
            end
            ST_PREPQ: begin
                u_a   = q1_reg;
                u_cin = wrap_reg;
            end
            ST_EVAL: begin
                if (chk_reg) begin
                    u_op = OP_DIV;
                    u_a  = rem_reg;
                    u_b  = p_reg;
                end else begin
                    u_a   = bq_reg[W-1:0];
                    u_cin = 1'b1;
                end
            end
            ST_MUL: begin
                u_a = acc_reg;
                u_b = mulr_reg[0] ? m_reg : '0;
            end
            default: begin
                u_op = OP_ADD;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        p_next     = p_reg;
        rem_next   = rem_reg;
        q1_next    = q1_reg;
        q2_next    = q2_reg;
        c2_next    = c2_reg;
        bq_next    = bq_reg;
        m_next     = m_reg;
        acc_next   = acc_reg;
        mulr_next  = mulr_reg;
        cnt_next   = cnt_reg;
        s_next     = s_reg;
        wrap_next  = wrap_reg;
        chk_next   = chk_reg;
        rm_next    = rm_reg;
        rs_next    = rs_reg;
        rf_next    = rf_reg;
        mv_next    = mv_reg;
        om_next    = om_reg;
        os_next    = os_reg;
        of_next    = of_reg;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    p_next   = s_divisor[W-1:0];
                    rem_next = '0;
                    q1_next  = '0;
                    cnt_next = '0;
                    s_next   = '0;
                    chk_next = 1'b0;
                    rm_next  = '0;
                    rs_next  = '0;
                    rf_next  = 1'b0;
                    state_next = (s_divisor[W-1:0] == '0) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = u_res;
                q1_next  = {q1_reg[W-2:0], u_flag};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(W-1)) begin
                    state_next = ST_PREPC2;
                end
            end
            ST_PREPC2: begin
                c2_next    = u_res;
                state_next = ST_PREPQ2;
            end
            ST_PREPQ2: begin
                q2_next    = u_res;
                state_next = ST_PREPR;
            end
            ST_PREPR: begin
                wrap_next  = (u_sum == {1'b0, p_reg});
                rem_next   = (u_sum == {1'b0, p_reg}) ? '0 : u_res;
                state_next = ST_PREPQ;
            end
            ST_PREPQ: begin
                bq_next    = u_sum;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (chk_reg) begin
                    // advance to next shift: Q = 2Q + bit, r updated
                    chk_next = 1'b0;
                    rem_next = u_res;
                    bq_next  = {bq_reg[W-1:0], u_flag};
                    s_next   = s_inc[CW-1:0];
                    if (last_trial) begin
                        state_next = ST_DONE;
                    end
                end else begin
                    m_next = u_res;
                    if (pass12 && pass3) begin
                        acc_next   = '0;
                        mulr_next  = c2_reg;
                        cnt_next   = '0;
                        state_next = ST_MUL;
                    end else begin
                        chk_next = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                acc_next  = u_sum[W:1];
                mulr_next = mulr_reg >> 1;
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(W-1)) begin
                    if ((u_sum[W:1] >> s_reg) == q2_reg) begin
                        rm_next    = m_reg;
                        rs_next    = s_reg;
                        rf_next    = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        chk_next   = 1'b1;
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    om_next    = rm_reg;
                    os_next    = rs_reg;
                    of_next    = rf_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
        p_reg    <= p_next;
        rem_reg  <= rem_next;
        q1_reg   <= q1_next;
        q2_reg   <= q2_next;
        c2_reg   <= c2_next;
        bq_reg   <= bq_next;
        m_reg    <= m_next;
        acc_reg  <= acc_next;
        mulr_reg <= mulr_next;
        cnt_reg  <= cnt_next;
        s_reg    <= s_next;
        wrap_reg <= wrap_next;
        chk_reg  <= chk_next;
        rm_reg   <= rm_next;
        rs_reg   <= rs_next;
        rf_reg   <= rf_next;
        om_reg   <= om_next;
        os_reg   <= os_next;
        of_reg   <= of_next;
    end

endmodule

// ===== sv/idms_step_unit.sv =====
// ----------------------------------------------------------------------------
// idms_step_unit: shared add/subtract unit
// One adder serves restoring-division steps (shift in a bit, compare and
// subtract the divisor) and plain additions with carry in.
// ----------------------------------------------------------------------------
module idms_step_unit #(
    parameter int W = 64
) (
    input  idms_pkg::idms_op_t op,
    input  logic [W-1:0]       a,
    input  logic [W-1:0]       b,
    input  logic               bit_in,
    input  logic               cin,
    output logic [W-1:0]       result,
    output logic               flag,
    output logic [W:0]         sum_out
);
    import idms_pkg::*;

    logic [W:0]   x;
    logic [W:0]   y;
    logic         c;
    logic [W+1:0] sum;

    always_comb begin
        unique case (op)
            OP_DIV: begin
                x = {a, bit_in};
                y = ~{1'b0, b};
                c = 1'b1;
            end
            OP_ADD: begin
                x = {1'b0, a};
                y = {1'b0, b};
                c = cin;
            end
            default: begin
                x = '0;
                y = '0;
                c = 1'b0;
            end
        endcase
        sum = {1'b0, x} + {1'b0, y} + {{(W+1){1'b0}}, c};
        if (op == OP_DIV) begin
            flag   = sum[W+1];
            result = sum[W+1] ? sum[W-1:0] : x[W-1:0];
        end else begin
            flag   = sum[W];
            result = sum[W-1:0];
        end
        sum_out = sum[W:0];
    end

endmodule

// ===== sv/idms_checker.sv =====
// ----------------------------------------------------------------------------
// idms_checker: port-level checks for the magic search core
// Watches the top-level ports and flags protocol and result slips.
// ----------------------------------------------------------------------------
module idms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [63:0] s_divisor,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_multiplier,
    input logic [5:0]  m_shift_amount,
    input logic        m_found
);

    // divisor held until its transfer
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_divisor))
        else $error("divisor dropped or changed before transfer");

    // result held until its transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_multiplier))
        else $error("result dropped or changed before transfer");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_multiplier == 64'd0 && m_shift_amount == 6'd0)
        else $error("failed search with nonzero fields");

    a_found_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_multiplier != 64'd0)
        else $error("found result with zero multiplier");

    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while search in flight");

endmodule

bind invariant_divisor_magic_search_core idms_checker u_idms_checker (.*);
